/* rtl/core/rhs_pkg.sv */
// rhs_pkg: shared constants, status codes and packet summary type
// for the rtp header strip block
// no dependencies
package rhs_pkg;

    // packet size limit and derived widths
    localparam int MAX_PACKET = 4096;
    localparam int IDX_W      = $clog2(MAX_PACKET + 2);
    localparam int OUT_W      = 13;
    localparam int STATUS_W   = 3;
    localparam int KIND_W     = 7;
    localparam int EXTB_W     = 19;

    // header layout
    localparam logic [7:0] PREFIX_MARK   = 8'h24;
    localparam int         PREFIX_LEN    = 4;
    localparam int         RTP_FIXED_LEN = 12;
    localparam int         MEDIA_HDR_LEN = 4;
    localparam int         HDR_W         = 7;

    // reset value of the bare payload type register
    localparam logic [KIND_W-1:0] BARE_PT_RESET = 7'd33;

    // summary queue depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_PREFIX      = 3'd1,
        ST_SHORT       = 3'd2,
        ST_NO_EXT_ROOM = 3'd3,
        ST_EXT_OVERRUN = 3'd4,
        ST_TOO_LONG    = 3'd5
    } status_t;

    // what the front end knows about a packet once its last byte is in
    typedef struct packed {
        logic [IDX_W-1:0]  n_bytes;
        logic              too_long;
        logic              interleaved;
        logic [15:0]       declared_length;
        logic              has_padding;
        logic [7:0]        last_byte;
        logic [3:0]        csrc_count;
        logic              bare_match;
        logic              has_extension;
        logic [15:0]       extension_words;
        logic [KIND_W-1:0] kind;
        logic              marker;
    } pkt_sum_t;

endpackage

/* rtl/core/rhs_if.sv */
// rhs_if: valid/ready channel interfaces for the byte input and result output
// depends on rhs_pkg

interface rhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface rhs_out_if import rhs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    payload_offset;
    logic [OUT_W-1:0]    payload_length;
    logic [KIND_W-1:0]   payload_kind;
    logic                marker_bit;

    modport source (output valid, output status, output payload_offset,
                    output payload_length, output payload_kind, output marker_bit,
                    input ready);
    modport sink (input valid, input status, input payload_offset,
                  input payload_length, input payload_kind, input marker_bit,
                  output ready);
endinterface

/* rtl/core/rhs_front.sv */
// rhs_front: takes packet bytes, captures header fields, pushes a summary
// on the last byte of each packet; depends on rhs_pkg and rhs_if
module rhs_front
    import rhs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rhs_in_if.sink            in_ch,
    input  logic [KIND_W-1:0] bare_payload_type,
    input  logic              push_ready,
    output logic              push,
    output pkt_sum_t          summary
);

    logic [IDX_W-1:0]  byte_idx_reg, byte_idx_next;
    logic              interleaved_reg, interleaved_next;
    logic [15:0]       decl_len_reg, decl_len_next;
    logic [3:0]        csrc_reg, csrc_next;
    logic              has_ext_reg, has_ext_next;
    logic              has_pad_reg, has_pad_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              marker_reg, marker_next;
    logic [15:0]       ext_words_reg, ext_words_next;

    logic              accept;
    logic              in_range;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  base_old;
    logic [IDX_W-1:0]  ext_pos;
    logic [IDX_W-1:0]  idx_cap;
    logic              int_cap;
    logic [15:0]       decl_cap;
    logic [3:0]        csrc_cap;
    logic              ext_cap;
    logic              pad_cap;
    logic [KIND_W-1:0] kind_cap;
    logic              marker_cap;
    logic [15:0]       ew_cap;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign push        = accept && in_ch.last;

    // field capture for the byte at the current position
    always_comb
    begin
        pos      = byte_idx_reg;
        in_range = (pos < IDX_W'(MAX_PACKET));
        base_old = interleaved_reg ? IDX_W'(PREFIX_LEN) : '0;
        ext_pos  = (interleaved_reg ? IDX_W'(PREFIX_LEN) : '0) + IDX_W'(RTP_FIXED_LEN)
                 + IDX_W'({csrc_reg, 2'b00})
                 + ((kind_reg != bare_payload_type) ? IDX_W'(MEDIA_HDR_LEN) : '0);

        idx_cap    = byte_idx_reg;
        int_cap    = interleaved_reg;
        decl_cap   = decl_len_reg;
        csrc_cap   = csrc_reg;
        ext_cap    = has_ext_reg;
        pad_cap    = has_pad_reg;
        kind_cap   = kind_reg;
        marker_cap = marker_reg;
        ew_cap     = ext_words_reg;

        if (in_range)
        begin
            idx_cap = pos + IDX_W'(1);
            if (pos == '0 && in_ch.data_byte == PREFIX_MARK)
            begin
                int_cap = 1'b1;
            end
            if (int_cap && pos == IDX_W'(2))
            begin
                decl_cap[15:8] = in_ch.data_byte;
            end
            if (int_cap && pos == IDX_W'(3))
            begin
                decl_cap[7:0] = in_ch.data_byte;
            end
            if (pos == base_old)
            begin
                csrc_cap = in_ch.data_byte[3:0];
                ext_cap  = in_ch.data_byte[4];
                pad_cap  = in_ch.data_byte[5];
            end
            if (pos == base_old + IDX_W'(1))
            begin
                kind_cap   = in_ch.data_byte[6:0];
                marker_cap = in_ch.data_byte[7];
            end
            if (pos > base_old + IDX_W'(1))
            begin
                if (pos == ext_pos + IDX_W'(2))
                begin
                    ew_cap[15:8] = in_ch.data_byte;
                end
                if (pos == ext_pos + IDX_W'(3))
                begin
                    ew_cap[7:0] = in_ch.data_byte;
                end
            end
        end
        else
        begin
            idx_cap = IDX_W'(MAX_PACKET + 1);
        end
    end

    // packet summary handed to the queue
    always_comb
    begin
        summary.n_bytes         = idx_cap;
        summary.too_long        = !in_range;
        summary.interleaved     = int_cap;
        summary.declared_length = decl_cap;
        summary.has_padding     = pad_cap;
        summary.last_byte       = in_ch.data_byte;
        summary.csrc_count      = csrc_cap;
        summary.bare_match      = (kind_cap == bare_payload_type);
        summary.has_extension   = ext_cap;
        summary.extension_words = ew_cap;
        summary.kind            = kind_cap;
        summary.marker          = marker_cap;
    end

    // next state: hold, capture, or clear after the last byte
    always_comb
    begin
        byte_idx_next    = byte_idx_reg;
        interleaved_next = interleaved_reg;
        decl_len_next    = decl_len_reg;
        csrc_next        = csrc_reg;
        has_ext_next     = has_ext_reg;
        has_pad_next     = has_pad_reg;
        kind_next        = kind_reg;
        marker_next      = marker_reg;
        ext_words_next   = ext_words_reg;
        if (accept)
        begin
            if (in_ch.last)
            begin
                byte_idx_next    = '0;
                interleaved_next = 1'b0;
                decl_len_next    = '0;
                csrc_next        = '0;
                has_ext_next     = 1'b0;
                has_pad_next     = 1'b0;
                kind_next        = '0;
                marker_next      = 1'b0;
                ext_words_next   = '0;
            end
            else
            begin
                byte_idx_next    = idx_cap;
                interleaved_next = int_cap;
                decl_len_next    = decl_cap;
                csrc_next        = csrc_cap;
                has_ext_next     = ext_cap;
                has_pad_next     = pad_cap;
                kind_next        = kind_cap;
                marker_next      = marker_cap;
                ext_words_next   = ew_cap;
            end
        end
    end

    // packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg    <= '0;
            interleaved_reg <= 1'b0;
            decl_len_reg    <= '0;
            csrc_reg        <= '0;
            has_ext_reg     <= 1'b0;
            has_pad_reg     <= 1'b0;
            kind_reg        <= '0;
            marker_reg      <= 1'b0;
            ext_words_reg   <= '0;
        end
        else
        begin
            byte_idx_reg    <= byte_idx_next;
            interleaved_reg <= interleaved_next;
            decl_len_reg    <= decl_len_next;
            csrc_reg        <= csrc_next;
            has_ext_reg     <= has_ext_next;
            has_pad_reg     <= has_pad_next;
            kind_reg        <= kind_next;
            marker_reg      <= marker_next;
            ext_words_reg   <= ext_words_next;
        end
    end

endmodule

/* rtl/core/rhs_fifo.sv */
// rhs_fifo: short queue of packet summaries between front and back end
// depends on rhs_pkg
module rhs_fifo
    import rhs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pkt_sum_t push_data,
    output logic     push_ready,
    input  logic     pop,
    output logic     pop_valid,
    output pkt_sum_t pop_data
);

    pkt_sum_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (FIFO_AW + 1)'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/rhs_back.sv */
// rhs_back: two-stage length and offset computation with output register
// depends on rhs_pkg and rhs_if
module rhs_back
    import rhs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sum_valid,
    input  pkt_sum_t sum_data,
    output logic     sum_pop,
    rhs_out_if.source out_ch
);

    typedef struct packed {
        logic              early_err;
        status_t           early_code;
        logic [IDX_W-1:0]  len1;
        logic [HDR_W-1:0]  hdr;
        logic [HDR_W:0]    hdr_plus4;
        logic              has_ext;
        logic [EXTB_W-1:0] strip_total;
        logic [EXTB_W-1:0] off_full;
        logic [KIND_W-1:0] kind;
        logic              marker;
    } stage1_t;

    stage1_t           s1_reg, s1_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [OUT_W-1:0]  offset_reg, offset_next;
    logic [OUT_W-1:0]  length_reg, length_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              marker_reg, marker_next;

    logic              out_load;
    logic              s1_load;
    logic              mismatch;
    logic [IDX_W-1:0]  len0;
    logic [EXTB_W-1:0] ext_bytes;

    assign out_load = !out_valid_reg || out_ch.ready;
    assign s1_load  = !s1_valid_reg || out_load;
    assign sum_pop  = s1_load;

    // stage 1: prefix check, padding removal, header and extension sizes
    always_comb
    begin
        mismatch = (sum_data.n_bytes < IDX_W'(PREFIX_LEN))
                || (sum_data.declared_length
                    != 16'(sum_data.n_bytes - IDX_W'(PREFIX_LEN)));
        len0 = sum_data.interleaved ? sum_data.n_bytes - IDX_W'(PREFIX_LEN)
                                    : sum_data.n_bytes;
        ext_bytes = EXTB_W'({sum_data.extension_words, 2'b00}) + EXTB_W'(4);

        s1_next.early_err  = sum_data.too_long || (sum_data.interleaved && mismatch);
        s1_next.early_code = sum_data.too_long ? ST_TOO_LONG : ST_PREFIX;
        if (sum_data.has_padding
            && len0 >= IDX_W'(RTP_FIXED_LEN) + IDX_W'(sum_data.last_byte))
        begin
            s1_next.len1 = len0 - IDX_W'(sum_data.last_byte);
        end
        else
        begin
            s1_next.len1 = len0;
        end
        s1_next.hdr = HDR_W'(RTP_FIXED_LEN) + HDR_W'({sum_data.csrc_count, 2'b00})
                    + (sum_data.bare_match ? '0 : HDR_W'(MEDIA_HDR_LEN));
        s1_next.hdr_plus4   = (HDR_W + 1)'(s1_next.hdr) + (HDR_W + 1)'(4);
        s1_next.has_ext     = sum_data.has_extension;
        s1_next.strip_total = EXTB_W'(s1_next.hdr)
                            + (sum_data.has_extension ? ext_bytes : '0);
        s1_next.off_full    = s1_next.strip_total
                            + (sum_data.interleaved ? EXTB_W'(PREFIX_LEN) : '0);
        s1_next.kind        = sum_data.kind;
        s1_next.marker      = sum_data.marker;

        s1_valid_next = s1_load ? sum_valid : s1_valid_reg;
    end

    // stage 2: final status, offset and length into the output register
    always_comb
    begin
        status_next    = status_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        kind_next      = kind_reg;
        marker_next    = marker_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
            kind_next      = s1_reg.kind;
            marker_next    = s1_reg.marker;
            offset_next    = '0;
            length_next    = '0;
            if (s1_reg.early_err)
            begin
                status_next = s1_reg.early_code;
            end
            else if (s1_reg.len1 < IDX_W'(s1_reg.hdr))
            begin
                status_next = ST_SHORT;
            end
            else if (s1_reg.has_ext && s1_reg.len1 < IDX_W'(s1_reg.hdr_plus4))
            begin
                status_next = ST_NO_EXT_ROOM;
            end
            else if (s1_reg.has_ext && EXTB_W'(s1_reg.len1) < s1_reg.strip_total)
            begin
                status_next = ST_EXT_OVERRUN;
            end
            else
            begin
                status_next = ST_OK;
                offset_next = OUT_W'(s1_reg.off_full);
                length_next = OUT_W'(s1_reg.len1 - IDX_W'(s1_reg.strip_total));
            end
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= s1_next;
        end
        status_reg <= status_next;
        offset_reg <= offset_next;
        length_reg <= length_next;
        kind_reg   <= kind_next;
        marker_reg <= marker_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.payload_offset = offset_reg;
    assign out_ch.payload_length = length_reg;
    assign out_ch.payload_kind   = kind_reg;
    assign out_ch.marker_bit     = marker_reg;

endmodule

/* rtl/core/rtp_header_strip_top.sv */
// rtp_header_strip_top: byte-stream rtp header parser, top level
// depends on rhs_pkg, rhs_if, rhs_front, rhs_fifo, rhs_back
//
// Takes one packet byte per clock on in_ch and gives one result per packet
// on out_ch: status, offset and length of the payload after an optional
// interleaved prefix, the RTP header, CSRC list, media header, header
// extension and padding, plus the payload type and marker bit. For every
// byte the front end only updates a counter and a few captured fields. On
// the last byte a packet summary enters a four-entry queue, and the back
// end turns it into a result in two register stages. in_ch.ready drops
// only while the queue is full. Packets above 4096 bytes report status 5.
// bare_payload_type resets to 33 and is written through cfg_we/cfg_wdata.
module rtp_header_strip_top
    import rhs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KIND_W-1:0] cfg_wdata,
    rhs_in_if.sink            in_ch,
    rhs_out_if.source         out_ch
);

    logic [KIND_W-1:0] bare_pt_reg, bare_pt_next;
    logic              push;
    logic              push_ready;
    pkt_sum_t          push_data;
    logic              sum_valid;
    logic              sum_pop;
    pkt_sum_t          sum_data;

    // configuration register
    assign bare_pt_next = cfg_we ? cfg_wdata : bare_pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bare_pt_reg <= BARE_PT_RESET;
        end
        else
        begin
            bare_pt_reg <= bare_pt_next;
        end
    end

    rhs_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_ch             (in_ch),
        .bare_payload_type (bare_pt_reg),
        .push_ready        (push_ready),
        .push              (push),
        .summary           (push_data)
    );

    rhs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (sum_pop),
        .pop_valid  (sum_valid),
        .pop_data   (sum_data)
    );

    rhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .sum_pop   (sum_pop),
        .out_ch    (out_ch)
    );

endmodule

/* rtl/core/rhs_checker.sv */
// rhs_checker: port-level assertions for rtp_header_strip_top, bound to it
// depends on rhs_pkg
module rhs_checker
    import rhs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [OUT_W-1:0]    payload_offset,
    input logic [OUT_W-1:0]    payload_length
);

    // a stalled result beat stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result beat keeps its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(payload_offset)
                                    && $stable(payload_length))
        else $error("result changed while stalled");

    // errors report an empty payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> payload_offset == '0 && payload_length == '0)
        else $error("error result with nonzero offset or length");

    // a good packet's payload lies past the fixed header and inside the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            payload_offset >= OUT_W'(RTP_FIXED_LEN)
            && (OUT_W + 1)'(payload_offset) + (OUT_W + 1)'(payload_length)
               <= (OUT_W + 1)'(MAX_PACKET))
        else $error("payload outside packet bounds");

endmodule

bind rtp_header_strip_top rhs_checker u_rhs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .payload_offset (out_ch.payload_offset),
    .payload_length (out_ch.payload_length)
);

/* tb/rtp_header_strip_checker.sv */
// rtp_header_strip_checker: watches the byte and result channels of the rtp
// header strip block, predicts each packet result and compares it field by field
// depends on rhs_pkg and rhs_if
module rtp_header_strip_checker
    import rhs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KIND_W-1:0] cfg_wdata,
    rhs_in_if                 in_ch,
    rhs_out_if                out_ch,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    localparam int MAX_LINES = 30;

    typedef struct packed {
        status_t           status;
        logic [OUT_W-1:0]  offset;
        logic [OUT_W-1:0]  length;
        logic [KIND_W-1:0] kind;
        logic              marker;
    } strip_result_t;

    strip_result_t expected_q[$];

    // register copy and per-packet capture
    logic [KIND_W-1:0] bare_kind;
    logic [12:0]       seen_bytes;
    logic              is_interleaved;
    logic [15:0]       prefix_length;
    logic [3:0]        csrc_cnt;
    logic              ext_flag;
    logic              pad_flag;
    logic [KIND_W-1:0] pkt_kind;
    logic              pkt_marker;
    logic [15:0]       ext_words;

    int mismatches;
    int results_seen;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_LINES)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      results_seen, name, got, want));
    endtask

    function automatic void clear_packet();
        seen_bytes     = '0;
        is_interleaved = 1'b0;
        prefix_length  = '0;
        csrc_cnt       = '0;
        ext_flag       = 1'b0;
        pad_flag       = 1'b0;
        pkt_kind       = '0;
        pkt_marker     = 1'b0;
        ext_words      = '0;
    endfunction

    // index just past fixed header, csrc list and media header
    function automatic int header_end();
        int p;
        p = (is_interleaved ? PREFIX_LEN : 0) + RTP_FIXED_LEN + 4 * int'(csrc_cnt);
        if (pkt_kind != bare_kind)
            p += MEDIA_HDR_LEN;
        return p;
    endfunction

    // capture header fields from one beat
    function automatic void take_byte(input logic [7:0] b);
        int pos;
        int base;
        int ext_at;
        pos  = int'(seen_bytes);
        base = is_interleaved ? PREFIX_LEN : 0;
        if (pos == 0 && b == PREFIX_MARK)
            is_interleaved = 1'b1;
        if (is_interleaved && pos == 2)
            prefix_length[15:8] = b;
        if (is_interleaved && pos == 3)
            prefix_length[7:0] = b;
        if (pos == base)
        begin
            csrc_cnt = b[3:0];
            ext_flag = b[4];
            pad_flag = b[5];
        end
        if (pos == base + 1)
        begin
            pkt_kind   = b[6:0];
            pkt_marker = b[7];
        end
        if (pos > base + 1)
        begin
            ext_at = header_end();
            if (pos == ext_at + 2)
                ext_words[15:8] = b;
            if (pos == ext_at + 3)
                ext_words[7:0] = b;
        end
    endfunction

    // work out the packet result on its last beat
    function automatic strip_result_t close_packet(input logic [7:0] last_b,
                                                   input logic overflow);
        strip_result_t r;
        int n;
        int len;
        int off;
        int ext_len;
        int base;
        r.status = ST_OK;
        r.offset = '0;
        r.length = '0;
        r.kind   = pkt_kind;
        r.marker = pkt_marker;
        n    = int'(seen_bytes);
        base = is_interleaved ? PREFIX_LEN : 0;
        if (overflow)
        begin
            r.status = ST_TOO_LONG;
            return r;
        end
        len = n;
        if (is_interleaved)
        begin
            if (int'(prefix_length) != n - PREFIX_LEN)
            begin
                r.status = ST_PREFIX;
                return r;
            end
            len = n - PREFIX_LEN;
        end
        // padding comes off only when it fits behind a fixed header
        if (pad_flag && len >= RTP_FIXED_LEN + int'(last_b))
            len -= int'(last_b);
        off = header_end();
        len -= off - base;
        if (len < 0)
        begin
            r.status = ST_SHORT;
            return r;
        end
        if (ext_flag)
        begin
            if (len < 4)
            begin
                r.status = ST_NO_EXT_ROOM;
                return r;
            end
            ext_len = (int'(ext_words) + 1) * 4;
            if (len < ext_len)
            begin
                r.status = ST_EXT_OVERRUN;
                return r;
            end
            len -= ext_len;
            off += ext_len;
        end
        r.offset = off[OUT_W-1:0];
        r.length = len[OUT_W-1:0];
        return r;
    endfunction

    // predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin : track
        strip_result_t want;
        logic overflow;
        if (!rst_n)
        begin
            bare_kind = BARE_PT_RESET;
            clear_packet();
            expected_q.delete();
            mismatches   = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
                bare_kind = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
            begin
                overflow = 1'b0;
                if (seen_bytes < MAX_PACKET)
                begin
                    take_byte(in_ch.data_byte);
                    seen_bytes = seen_bytes + 1'b1;
                end
                else
                begin
                    overflow   = 1'b1;
                    seen_bytes = 13'(MAX_PACKET + 1);
                end
                if (in_ch.last)
                begin
                    expected_q.push_back(close_packet(in_ch.data_byte, overflow));
                    clear_packet();
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result beat with no packet pending");
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", 16'(out_ch.status), 16'(want.status));
                    check_field("payload_offset", 16'(out_ch.payload_offset),
                                16'(want.offset));
                    check_field("payload_length", 16'(out_ch.payload_length),
                                16'(want.length));
                    check_field("payload_kind", 16'(out_ch.payload_kind),
                                16'(want.kind));
                    check_field("marker_bit", 16'(out_ch.marker_bit), 16'(want.marker));
                    results_seen++;
                end
            end
        end
        fail_count <= mismatches;
        pending    <= expected_q.size();
        checked    <= results_seen;
    end

endmodule

/* tb/rtp_header_strip_top_tb.sv */
// rtp_header_strip_top_tb: drives packets into the rtp header strip block with
// random gaps and stalls, and gives the verdict from the checker's count
// depends on rhs_pkg, rhs_if, rtp_header_strip_top and rtp_header_strip_checker
module rtp_header_strip_top_tb;
    import rhs_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_BYTES  = 1200;
    localparam int MIN_PACKETS   = 32;
    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [KIND_W-1:0] cfg_wdata;

    rhs_in_if  in_ch();
    rhs_out_if out_ch();

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int packets_sent = 0;
    int bytes_sent = 0;
    logic steady;
    logic [KIND_W-1:0] bare_type_now;
    logic [7:0] pkt[$];

    rtp_header_strip_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    rtp_header_strip_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
        out_ch.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);

    // one beat, with random gaps in front of it
    task automatic send_byte(input logic [7:0] b, input logic l);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last      <= l;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // wait until every packet result is out and the block has gone quiet
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_bare_type(input logic [KIND_W-1:0] v);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we        <= 1'b0;
        bare_type_now = v;
    endtask

    // well-formed packet with random sequence, timestamp, ssrc and payload
    function automatic void build_packet(input bit prefixed, input int cc, input bit ext,
                                         input logic [15:0] ext_n, input int pad_n,
                                         input logic [KIND_W-1:0] kind, input bit mark,
                                         input int body_n);
        int plen;
        pkt.delete();
        if (prefixed)
        begin
            pkt.push_back(PREFIX_MARK);
            pkt.push_back(8'($urandom));
            pkt.push_back(8'h00);
            pkt.push_back(8'h00);
        end
        pkt.push_back({2'b10, (pad_n != 0), ext, cc[3:0]});
        pkt.push_back({mark, kind});
        repeat (10 + 4 * cc) pkt.push_back(8'($urandom));
        if (kind != bare_type_now)
            repeat (MEDIA_HDR_LEN) pkt.push_back(8'($urandom));
        if (ext)
        begin
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
            pkt.push_back(ext_n[15:8]);
            pkt.push_back(ext_n[7:0]);
            repeat (4 * int'(ext_n)) pkt.push_back(8'($urandom));
        end
        repeat (body_n) pkt.push_back(8'($urandom));
        if (pad_n != 0)
        begin
            repeat (pad_n - 1) pkt.push_back(8'($urandom));
            pkt.push_back(pad_n[7:0]);
        end
        if (prefixed)
        begin
            plen   = pkt.size() - PREFIX_LEN;
            pkt[2] = plen[15:8];
            pkt[3] = plen[7:0];
        end
    endfunction

    // mostly well-formed packets, some cut, some noise, some with bad fields
    task automatic random_packet();
        int shape;
        int noise_n;
        bit prefixed;
        shape    = $urandom_range(99);
        prefixed = $urandom_range(99) < 30;
        build_packet(prefixed,
                     ($urandom_range(99) < 70) ? 0 : $urandom_range(15),
                     $urandom_range(99) < 30,
                     16'($urandom_range(3)),
                     ($urandom_range(99) < 30) ? $urandom_range(12, 1) : 0,
                     ($urandom_range(99) < 40) ? bare_type_now : 7'($urandom_range(127)),
                     $urandom_range(1),
                     $urandom_range(40));
        if (shape < 8)
            pkt = pkt[0:$urandom_range(pkt.size() - 1)];
        else if (shape < 12)
        begin
            noise_n = $urandom_range(30, 1);
            pkt.delete();
            repeat (noise_n) pkt.push_back(8'($urandom));
        end
        else if (shape < 15 && prefixed)
            pkt[2] = 8'($urandom);
        else if (shape < 18)
            pkt[$] = 8'($urandom);
        send_packet();
    endtask

    initial
    begin : stimulus
        int start_bytes;
        int n;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= BARE_PT_RESET;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last      <= 1'b0;
        steady          <= 1'b0;
        bare_type_now   = BARE_PT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bare type at its reset value: header only
        build_packet(0, 0, 0, 16'd0, 0, BARE_PT_RESET, 0, 0);
        send_packet();
        // other kind, media header skipped
        build_packet(0, 0, 0, 16'd0, 0, 7'd96, 1, 5);
        send_packet();
        // interleaved, full csrc list, extension and padding
        build_packet(1, 15, 1, 16'd2, 3, 7'd127, 1, 9);
        send_packet();
        // prefix length off by one
        build_packet(1, 1, 0, 16'd0, 0, 7'd8, 0, 4);
        pkt[3] = pkt[3] ^ 8'h01;
        send_packet();
        // prefix mark on a packet too short to carry the length
        pkt = '{PREFIX_MARK, 8'h00, 8'h05};
        send_packet();
        // single byte, then a header cut off early
        pkt = '{8'hff};
        send_packet();
        build_packet(0, 0, 0, 16'd0, 0, 7'd0, 0, 0);
        pkt = pkt[0:5];
        send_packet();
        // extension flag with too little behind the header
        build_packet(0, 0, 0, 16'd0, 0, BARE_PT_RESET, 0, 2);
        pkt[0] = pkt[0] | 8'h10;
        send_packet();
        // extension length far beyond the packet
        build_packet(0, 0, 1, 16'd0, 0, BARE_PT_RESET, 0, 4);
        pkt[14] = 8'hff;
        pkt[15] = 8'hff;
        send_packet();
        // padding that fits, then a padding count larger than the packet
        build_packet(0, 2, 0, 16'd0, 8, 7'd5, 0, 3);
        send_packet();
        build_packet(0, 0, 0, 16'd0, 8, BARE_PT_RESET, 0, 0);
        pkt[$] = 8'hc8;
        send_packet();

        // bare type at both extremes
        set_bare_type(7'd0);
        build_packet(0, 0, 0, 16'd0, 0, 7'd0, 1, 3);
        send_packet();
        build_packet(1, 3, 1, 16'd1, 0, BARE_PT_RESET, 0, 2);
        send_packet();
        set_bare_type(7'd127);
        build_packet(0, 0, 0, 16'd0, 0, 7'd127, 1, 0);
        send_packet();
        build_packet(0, 0, 0, 16'd0, 0, 7'd0, 0, 0);
        send_packet();
        set_bare_type(BARE_PT_RESET);

        // random packets, with a stretch of no gaps or stalls
        start_bytes = bytes_sent;
        n = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES || n < MIN_PACKETS)
        begin
            if (n % 16 == 15)
                set_bare_type(7'($urandom_range(127)));
            steady <= (n >= 20 && n < 30);
            random_packet();
            n++;
        end

        // drain and verdict
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d packets in %0d bytes, %0d results checked",
                 packets_sent, bytes_sent, checked);
        $display("covered prefix, short, extension and padding cases, bare type 0/33/127/random");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rhs_pkg.sv
rtl/core/rhs_if.sv
rtl/core/rhs_front.sv
rtl/core/rhs_fifo.sv
rtl/core/rhs_back.sv
rtl/core/rtp_header_strip_top.sv
rtl/core/rhs_checker.sv
tb/rtp_header_strip_checker.sv
tb/rtp_header_strip_top_tb.sv
